// ===== rtl/core/tcspq_pkg.sv =====
// Package with the types and constants shared by the priority queue modules.
`default_nettype none
package tcspq_pkg;

  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 16;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_CALL = 1'b1;

  localparam logic [1:0] CLS_VIP    = 2'd0;
  localparam logic [1:0] CLS_MEMBER = 2'd1;
  localparam logic [1:0] CLS_GUEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_CALLED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]          cls;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // What each cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   le;      // valid and class same or better than the incoming item
    entry_t entry;
  } link_t;

  // Operation broadcast to every cell in the cycle an item is taken.
  typedef struct packed {
    logic   add;
    logic   call;
    entry_t entry;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcspq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
`default_nettype none
module tcspq_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire tcspq_pkg::op_t    op,
  input  wire tcspq_pkg::link_t  left,
  input  wire tcspq_pkg::link_t  right,
  output tcspq_pkg::link_t       self
);

  logic              valid;
  tcspq_pkg::entry_t entry;

  assign self.valid = valid;
  assign self.le    = valid && (entry.cls <= op.entry.cls);
  assign self.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.call) begin
      valid <= right.valid;
    end else if (op.add && !self.le) begin
      valid <= left.le ? 1'b1 : left.valid;
    end
  end

  // An add keeps every entry of the same or a better class in place, drops the
  // new entry into the first cell behind them and shifts the rest back by one.
  always_ff @(posedge clk) begin
    if (op.call) begin
      entry <= right.entry;
    end else if (op.add && !self.le) begin
      entry <= left.le ? op.entry : left.entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/three_class_stable_priority_queue_top.sv =====
// Top level of the three-class stable priority queue built from a chain of cells.
// The result of an accepted item appears in the output register in the next cycle.
// Throughput: one item per cycle while the result is not stalled; every cell decides shift, insert or hold in parallel.
// A stalled result blocks new items only while the output register is full.
// Reset (synchronous, active high) empties the queue and the output register.
`default_nettype none
module three_class_stable_priority_queue_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        mode,
  input  wire [1:0]  priority_class,
  input  wire [15:0] payload_tag,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] status,
  output logic [1:0] out_class,
  output logic [15:0] out_tag,
  output logic [4:0] occupancy_now
);

  localparam int CAP = tcspq_pkg::CAPACITY;

  tcspq_pkg::link_t                 links [CAP];
  tcspq_pkg::link_t                 head_link;
  tcspq_pkg::link_t                 tail_link;
  tcspq_pkg::op_t                   op;
  tcspq_pkg::entry_t                new_entry;
  logic [tcspq_pkg::OCC_W-1:0]      occupancy;
  logic [tcspq_pkg::OCC_W-1:0]      occupancy_next;
  logic                             accept;
  logic                             is_full;
  logic                             is_empty;
  logic [CAP-1:0]                   valid_vec;
  tcspq_pkg::status_t               status_next;
  logic                             out_valid_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign head_link = links[0];
  assign tail_link = links[CAP-1];
  assign is_full   = tail_link.valid;
  assign is_empty  = !head_link.valid;

  // The unused class code is served as Guest.
  assign new_entry.cls = (priority_class > tcspq_pkg::CLS_GUEST) ? tcspq_pkg::CLS_GUEST
                                                                 : priority_class;
  assign new_entry.tag = tcspq_pkg::TAG_BITS'(payload_tag);

  assign op.add   = accept && (mode == tcspq_pkg::MODE_ADD) && !is_full;
  assign op.call  = accept && (mode == tcspq_pkg::MODE_CALL) && !is_empty;
  assign op.entry = new_entry;

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      tcspq_pkg::link_t left_in;
      tcspq_pkg::link_t right_in;

      if (gi == 0) begin : g_first
        // The head has everything "ahead" of it, so a new entry lands here
        // unless the head itself ranks same or better.
        assign left_in = '{valid: 1'b1, le: 1'b1, entry: '0};
      end else begin : g_mid
        assign left_in = links[gi-1];
      end

      if (gi == CAP - 1) begin : g_last
        assign right_in = '{valid: 1'b0, le: 1'b0, entry: '0};
      end else begin : g_inner
        assign right_in = links[gi+1];
      end

      tcspq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .op    (op),
        .left  (left_in),
        .right (right_in),
        .self  (links[gi])
      );

      assign valid_vec[gi] = links[gi].valid;
    end
  endgenerate

  always_comb begin
    occupancy_next = occupancy;
    if (op.add) begin
      occupancy_next = occupancy + 1'b1;
    end else if (op.call) begin
      occupancy_next = occupancy - 1'b1;
    end
  end

  always_comb begin
    if (mode == tcspq_pkg::MODE_ADD) begin
      status_next = is_full ? tcspq_pkg::ST_FULL : tcspq_pkg::ST_ADDED;
    end else begin
      status_next = is_empty ? tcspq_pkg::ST_EMPTY : tcspq_pkg::ST_CALLED;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      out_class     <= op.call ? head_link.entry.cls : 2'd0;
      out_tag       <= op.call ? 16'(head_link.entry.tag) : 16'd0;
      occupancy_now <= 5'(occupancy_next);
    end
  end

  // The occupancy counter must agree with the valid bits held in the chain.
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occupancy))
    else $error("occupancy counter disagrees with cell valid bits");

  // Valid cells always form a prefix of the chain.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + CAP'(1)) & valid_vec) == '0)
    else $error("valid cells are not contiguous from the head");

  // An add never loses an item that was accepted while the queue had room.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    op.add |=> (int'(occupancy) == int'($past(occupancy)) + 1))
    else $error("accepted add did not grow the queue");

  // A reported result of an add always shows a non-empty queue.
  a_added_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == tcspq_pkg::ST_ADDED) |-> (occupancy_now != 5'd0))
    else $error("added result shows an empty queue");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the three-class stable priority queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    tcspq_pkg::status_t st;
    logic [1:0]         cls;
    logic [15:0]        tag;
    logic [4:0]         occ;
  } ticket_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        mode = 1'b0;
  logic [1:0]  priority_class = 2'd0;
  logic [15:0] payload_tag = 16'd0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire [1:0]   status;
  wire [1:0]   out_class;
  wire [15:0]  out_tag;
  wire [4:0]   occupancy_now;

  tcspq_pkg::entry_t lobby_q[$];
  ticket_t           pending_tickets[$];
  int                errors = 0;
  int                quiet_cycles = 0;
  int                rx_hold = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;

  three_class_stable_priority_queue_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .priority_class (priority_class),
    .payload_tag    (payload_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_class      (out_class),
    .out_tag        (out_tag),
    .occupancy_now  (occupancy_now)
  );

  always #2 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Applies one accepted item to the shadow queue and records the result it must give.
  task automatic predict_service(input logic m, input logic [1:0] c, input logic [15:0] t);
    ticket_t           tk;
    tcspq_pkg::entry_t e;
    int                pos;
    tk.st = tcspq_pkg::ST_ADDED;
    tk.cls = 2'd0;
    tk.tag = 16'd0;
    e.cls = (c > tcspq_pkg::CLS_GUEST) ? tcspq_pkg::CLS_GUEST : c;
    e.tag = t;
    if (m == tcspq_pkg::MODE_ADD) begin
      if (lobby_q.size() >= tcspq_pkg::CAPACITY) begin
        tk.st = tcspq_pkg::ST_FULL;
      end else begin
        // The new entry goes behind every entry of the same or a better class.
        pos = 0;
        foreach (lobby_q[i])
          if (lobby_q[i].cls <= e.cls) pos = i + 1;
        lobby_q.insert(pos, e);
      end
    end else if (lobby_q.size() == 0) begin
      tk.st = tcspq_pkg::ST_EMPTY;
    end else begin
      tk.st = tcspq_pkg::ST_CALLED;
      tk.cls = lobby_q[0].cls;
      tk.tag = lobby_q[0].tag;
      void'(lobby_q.pop_front());
    end
    tk.occ = 5'(lobby_q.size());
    pending_tickets.push_back(tk);
  endtask

  // Must be called right after a rising edge; returns right after one.
  task automatic send_item(input logic m, input logic [1:0] c, input logic [15:0] t);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    priority_class <= c;
    payload_tag <= t;
    do @(posedge clk); while (in_stall);
    predict_service(m, c, t);
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_call_on_empty();
    send_item(tcspq_pkg::MODE_CALL, 2'd3, 16'hFFFF);
  endtask

  // Cycles through all four class codes, so the unused code lands with the guests,
  // and ends with one add that the full store must refuse.
  task automatic test_fill_and_refuse();
    logic [15:0] t;
    for (int i = 0; i <= tcspq_pkg::CAPACITY; i++) begin
      if (i == 0) t = 16'h0000;
      else if (i == 4) t = 16'hFFFF;
      else t = 16'($urandom);
      send_item(tcspq_pkg::MODE_ADD, 2'(i % 4), t);
    end
  endtask

  task automatic test_drain_order();
    repeat (5) send_item(tcspq_pkg::MODE_CALL, 2'($urandom), 16'($urandom));
  endtask

  task automatic test_random_traffic();
    int sent;
    int add_pct;
    int seg_len;
    logic m;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: add_pct = 15;
        1: add_pct = 50;
        default: add_pct = 85;
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(20, 80);
      repeat (seg_len) begin
        m = ($urandom_range(0, 99) < add_pct) ? tcspq_pkg::MODE_ADD : tcspq_pkg::MODE_CALL;
        send_item(m, 2'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (rx_calm || $urandom_range(0, 1)) begin
      out_stall <= 1'b0;
      rx_hold = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      rx_hold = idle_len();
    end
  end

  always @(posedge clk) begin : check_results
    ticket_t tk;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[three_class_stable_priority_queue_top] ERROR");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (pending_tickets.size() == 0) begin
          report_mismatch("unexpected result, status", status, 0);
        end else begin
          tk = pending_tickets.pop_front();
          if (status !== tk.st) report_mismatch("status", status, tk.st);
          if (out_class !== tk.cls) report_mismatch("out_class", out_class, tk.cls);
          if (out_tag !== tk.tag) report_mismatch("out_tag", out_tag, tk.tag);
          if (occupancy_now !== tk.occ) report_mismatch("occupancy_now", occupancy_now, tk.occ);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_call_on_empty();
    test_fill_and_refuse();
    test_drain_order();
    test_random_traffic();
    in_valid <= 1'b0;
    rx_calm = 1'b1;
    while (pending_tickets.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("[three_class_stable_priority_queue_top] OK");
    else
      $display("[three_class_stable_priority_queue_top] ERROR");
    $finish;
  end

endmodule
